// ===== sv/teabc_pkg.sv =====
// shared types, constants and round function for the tea block cipher unit
package teabc_pkg;

  // round count default and key schedule constant
  localparam int          ROUNDS_DEFAULT = 32;
  localparam logic [31:0] DELTA          = 32'h9E37_79B9;

  // key words loaded at reset
  localparam logic [31:0] KEY0_RESET = 32'h2011_0524;
  localparam logic [31:0] KEY1_RESET = 32'hAA00_1652;
  localparam logic [31:0] KEY2_RESET = 32'h1990_1979;
  localparam logic [31:0] KEY3_RESET = 32'h0422_0606;

  // configuration register indexes
  localparam int          CFG_IDX_W    = 3;
  localparam int          CFG_DATA_W   = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 3'd4;

  // input transaction payload
  typedef struct packed {
    logic [31:0] left_in;
    logic [31:0] right_in;
  } tea_in_t;

  // result transaction payload
  typedef struct packed {
    logic [31:0] left_out;
    logic [31:0] right_out;
  } tea_out_t;

  // block words as they move down the chain
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } blk_t;

  // configuration seen by every cell
  typedef struct packed {
    logic [31:0] key0;
    logic [31:0] key1;
    logic [31:0] key2;
    logic [31:0] key3;
    logic        decrypt;
  } cfg_t;

  // tea mixing function of one half round
  function automatic logic [31:0] mix(input logic [31:0] w, input logic [31:0] s,
                                      input logic [31:0] ka, input logic [31:0] kb);
    return ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
  endfunction

endpackage

// ===== sv/tea_block_cipher_unit.sv =====
// tea block cipher unit: chain of half-round cells with config registers
//
// Usage: one 64-bit block enters on the blk channel as two 32-bit words and
// one result block leaves on the res channel. A transaction moves at a rising
// edge where valid is high and stall is low. Keys and the decrypt mode bit are
// written through the cfg port (index 0..3 key words, 4 mode); the user must
// write them only while the unit holds no block, which the unit itself does
// not enforce. Other indexes are ignored. The chain holds one cell per half
// round, and each cell registers its result. The chain advances as a whole,
// so the unit takes one block per cycle while the receiver takes results.
// When the receiver stalls with a result waiting, the whole chain holds and
// blk_stall rises in the same cycle; blocks inside are kept, none is lost.
// Reset clears every valid bit and loads the built-in key with encrypt mode.
module tea_block_cipher_unit #(
  parameter int ROUNDS = teabc_pkg::ROUNDS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              blk_valid,
  output logic                              blk_stall,
  input  teabc_pkg::tea_in_t                blk_data,
  output logic                              res_valid,
  input  logic                              res_stall,
  output teabc_pkg::tea_out_t               res_data,
  input  logic                              cfg_write,
  input  logic [teabc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [teabc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int STAGES = 2 * ROUNDS;

  teabc_pkg::cfg_t cfg;
  logic            advance;
  logic            vld   [STAGES+1];
  teabc_pkg::blk_t words [STAGES+1];

  teabc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // chain moves whenever the output slot is free or being taken
  assign advance   = !res_valid || !res_stall;
  assign blk_stall = !advance;

  // chain head
  assign vld[0]     = blk_valid;
  assign words[0].a = blk_data.left_in;
  assign words[0].b = blk_data.right_in;

  // one cell per half round, sums fixed per position
  for (genvar j = 0; j < STAGES; j++) begin : g_cell
    localparam logic [31:0] ENC_S = 32'(32'(j / 2 + 1) * teabc_pkg::DELTA);
    localparam logic [31:0] DEC_S = 32'(32'(ROUNDS - j / 2) * teabc_pkg::DELTA);
    teabc_cell #(
      .ENC_SUM    (ENC_S),
      .DEC_SUM    (DEC_S),
      .FIRST_HALF ((j % 2) == 0)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .cfg        (cfg),
      .prev_valid (vld[j]),
      .prev_blk   (words[j]),
      .valid      (vld[j+1]),
      .blk        (words[j+1])
    );
  end

  // last cell is the output register
  assign res_valid          = vld[STAGES];
  assign res_data.left_out  = words[STAGES].a;
  assign res_data.right_out = words[STAGES].b;

  // input is held off only by a waiting, stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    blk_stall |-> (res_valid && res_stall))
    else $error("input stalled without a stalled result");

  // a stalled result is not dropped
  a_res_kept: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> res_valid)
    else $error("stalled result disappeared");

  // reset empties the chain
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

// ===== sv/teabc_cfg_regs.sv =====
// key and mode registers behind the configuration write port
module teabc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [teabc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [teabc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output teabc_pkg::cfg_t                     cfg
);

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key0    <= teabc_pkg::KEY0_RESET;
      cfg.key1    <= teabc_pkg::KEY1_RESET;
      cfg.key2    <= teabc_pkg::KEY2_RESET;
      cfg.key3    <= teabc_pkg::KEY3_RESET;
      cfg.decrypt <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        teabc_pkg::CFG_KEY0:    cfg.key0    <= cfg_data;
        teabc_pkg::CFG_KEY1:    cfg.key1    <= cfg_data;
        teabc_pkg::CFG_KEY2:    cfg.key2    <= cfg_data;
        teabc_pkg::CFG_KEY3:    cfg.key3    <= cfg_data;
        teabc_pkg::CFG_DECRYPT: cfg.decrypt <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/teabc_cell.sv =====
// one half round of tea with its pipeline register
module teabc_cell #(
  parameter logic [31:0] ENC_SUM    = teabc_pkg::DELTA,
  parameter logic [31:0] DEC_SUM    = teabc_pkg::DELTA,
  parameter bit          FIRST_HALF = 1'b1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  teabc_pkg::cfg_t  cfg,
  input  logic             prev_valid,
  input  teabc_pkg::blk_t  prev_blk,
  output logic             valid,
  output teabc_pkg::blk_t  blk
);

  logic            upd_a;
  logic [31:0]     src;
  logic [31:0]     dst;
  logic [31:0]     ka;
  logic [31:0]     kb;
  logic [31:0]     sum;
  logic [31:0]     m;
  logic [31:0]     dst_new;
  teabc_pkg::blk_t blk_next;

  // pick the word to update, its source and key pair for this half
  always_comb begin
    upd_a   = cfg.decrypt ? !FIRST_HALF : FIRST_HALF;
    src     = upd_a ? prev_blk.b : prev_blk.a;
    dst     = upd_a ? prev_blk.a : prev_blk.b;
    ka      = upd_a ? cfg.key0 : cfg.key2;
    kb      = upd_a ? cfg.key1 : cfg.key3;
    sum     = cfg.decrypt ? DEC_SUM : ENC_SUM;
    m       = teabc_pkg::mix(src, sum, ka, kb);
    dst_new = cfg.decrypt ? (dst - m) : (dst + m);
    blk_next.a = upd_a ? dst_new : prev_blk.a;
    blk_next.b = upd_a ? prev_blk.b : dst_new;
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= prev_valid;
    end
  end

  // block words
  always_ff @(posedge clk) begin
    if (advance) begin
      blk <= blk_next;
    end
  end

endmodule

// ===== tb/tea_block_cipher_unit_tb.sv =====
// self-checking testbench for the tea block cipher unit: directed table, then random key phases
module tea_block_cipher_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROUNDS     = teabc_pkg::ROUNDS_DEFAULT;
  localparam int DRAIN_CYCLES = 2 * NROUNDS + 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 75;
  localparam int MAX_REPORTS  = 10;

  // key schedule constant and power-on key, kept apart from the rtl package
  localparam logic [31:0] GOLDEN      = 32'h9E37_79B9;
  localparam logic [31:0] BOOT_KEY0   = 32'h2011_0524;
  localparam logic [31:0] BOOT_KEY1   = 32'hAA00_1652;
  localparam logic [31:0] BOOT_KEY2   = 32'h1990_1979;
  localparam logic [31:0] BOOT_KEY3   = 32'h0422_0606;

  // register indexes past the end of the register list
  localparam logic [teabc_pkg::CFG_IDX_W-1:0] IDX_PAST_LIST = teabc_pkg::CFG_DECRYPT + 3'd1;
  localparam logic [teabc_pkg::CFG_IDX_W-1:0] IDX_TOP       = '1;

  logic clk;
  logic rst = 1'b1;
  logic blk_valid = 1'b0;
  logic blk_stall;
  teabc_pkg::tea_in_t blk_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  teabc_pkg::tea_out_t res_data;
  logic cfg_write = 1'b0;
  logic [teabc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [teabc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the unit's configuration
  logic [31:0] key_w [4] = '{BOOT_KEY0, BOOT_KEY1, BOOT_KEY2, BOOT_KEY3};
  logic decrypt_on = 1'b0;

  // blocks in flight, oldest first
  teabc_pkg::tea_out_t cipher_q [$];
  teabc_pkg::tea_out_t want_blk;
  int fail_count = 0;

  // idle shaping and receiver hold-off
  bit quiet = 1'b0;
  logic hold_req = 1'b0;
  logic hold_on = 1'b0;

  tea_block_cipher_unit #(
    .ROUNDS(NROUNDS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .blk_valid(blk_valid),
    .blk_stall(blk_stall),
    .blk_data (blk_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one feistel half-round mixing term
  function automatic logic [31:0] feistel_f(input logic [31:0] w, input logic [31:0] s,
                                            input logic [31:0] ka, input logic [31:0] kb);
    return ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
  endfunction

  // full tea pass under the shadow key and mode
  function automatic teabc_pkg::tea_out_t tea_predict(input teabc_pkg::tea_in_t blk);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] s;
    teabc_pkg::tea_out_t r;
    a = blk.left_in;
    b = blk.right_in;
    if (decrypt_on) begin
      s = GOLDEN * NROUNDS;
      for (int n = 0; n < NROUNDS; n++) begin
        b = b - feistel_f(a, s, key_w[2], key_w[3]);
        a = a - feistel_f(b, s, key_w[0], key_w[1]);
        s = s - GOLDEN;
      end
    end else begin
      s = '0;
      for (int n = 0; n < NROUNDS; n++) begin
        s = s + GOLDEN;
        a = a + feistel_f(b, s, key_w[0], key_w[1]);
        b = b + feistel_f(a, s, key_w[2], key_w[3]);
      end
    end
    r.left_out  = a;
    r.right_out = b;
    return r;
  endfunction

  // random word biased toward zero, all ones, single set bits and single clear bits
  function automatic logic [31:0] rand_word();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(31);
      3: return ~(32'h1 << $urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  // offer one block, hold it until taken, then queue its prediction
  task automatic send_block(input teabc_pkg::tea_in_t blk);
    while (!quiet && $urandom_range(99) < 6) begin
      blk_valid <= 1'b0;
      @(posedge clk);
    end
    blk_valid <= 1'b1;
    blk_data  <= blk;
    @(posedge clk);
    while (blk_stall) @(posedge clk);
    cipher_q.push_back(tea_predict(blk));
  endtask

  // drive one register write; caller lowers cfg_write after the last one
  task automatic write_reg(input logic [teabc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      teabc_pkg::CFG_KEY0:    key_w[0] = val;
      teabc_pkg::CFG_KEY1:    key_w[1] = val;
      teabc_pkg::CFG_KEY2:    key_w[2] = val;
      teabc_pkg::CFG_KEY3:    key_w[3] = val;
      teabc_pkg::CFG_DECRYPT: decrypt_on = val[0];
      default: ;
    endcase
  endtask

  // stop offering and wait until every block has come back
  task automatic quiesce();
    blk_valid <= 1'b0;
    @(posedge clk);
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one random phase under a fixed key and mode
  task automatic run_phase(input logic [31:0] k0, input logic [31:0] k1,
                           input logic [31:0] k2, input logic [31:0] k3,
                           input logic [31:0] mode_word, input int n_items,
                           input bit no_idle, input bit squeeze);
    teabc_pkg::tea_in_t blk;
    quiesce();
    write_reg(teabc_pkg::CFG_KEY0, k0);
    write_reg(teabc_pkg::CFG_KEY1, k1);
    write_reg(teabc_pkg::CFG_KEY2, k2);
    write_reg(teabc_pkg::CFG_KEY3, k3);
    write_reg(teabc_pkg::CFG_DECRYPT, mode_word);
    write_reg(IDX_TOP, $urandom());
    cfg_write <= 1'b0;
    quiet = no_idle;
    if (squeeze) hold_req <= 1'b1;
    repeat (n_items) begin
      blk.left_in  = rand_word();
      blk.right_in = rand_word();
      send_block(blk);
    end
    quiet = 1'b0;
  endtask

  // directed table: blocks are checked against the predictor, config rows set up phases
  typedef enum logic {ROW_BLK, ROW_CFG} row_kind_t;
  typedef struct packed {
    row_kind_t                       kind;
    logic [teabc_pkg::CFG_IDX_W-1:0] idx;
    logic [31:0]                     word_a;
    logic [31:0]                     word_b;
  } stim_row_t;

  localparam int N_ROWS = 30;
  stim_row_t directed_rows [N_ROWS] = '{
    // boot key, encrypt: word extremes and patterns
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'h0000_0000, 32'h0000_0000},
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'h0000_0000, 32'hFFFF_FFFF},
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'hFFFF_FFFF, 32'h0000_0000},
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'hAAAA_AAAA, 32'h5555_5555},
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'h8000_0000, 32'h0000_0001},
    // boot key, decrypt
    '{ROW_CFG, teabc_pkg::CFG_DECRYPT, 32'h0000_0001, 32'h0},
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'h0000_0000, 32'h0000_0000},
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'h0123_4567, 32'h89AB_CDEF},
    // all-zero key, encrypt
    '{ROW_CFG, teabc_pkg::CFG_KEY0, 32'h0000_0000, 32'h0},
    '{ROW_CFG, teabc_pkg::CFG_KEY1, 32'h0000_0000, 32'h0},
    '{ROW_CFG, teabc_pkg::CFG_KEY2, 32'h0000_0000, 32'h0},
    '{ROW_CFG, teabc_pkg::CFG_KEY3, 32'h0000_0000, 32'h0},
    '{ROW_CFG, teabc_pkg::CFG_DECRYPT, 32'h0000_0000, 32'h0},
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'h0000_0000, 32'h0000_0000},
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    // all-ones key; writes past the register list must not touch the mode
    '{ROW_CFG, teabc_pkg::CFG_KEY0, 32'hFFFF_FFFF, 32'h0},
    '{ROW_CFG, teabc_pkg::CFG_KEY1, 32'hFFFF_FFFF, 32'h0},
    '{ROW_CFG, teabc_pkg::CFG_KEY2, 32'hFFFF_FFFF, 32'h0},
    '{ROW_CFG, teabc_pkg::CFG_KEY3, 32'hFFFF_FFFF, 32'h0},
    '{ROW_CFG, IDX_PAST_LIST, 32'h0000_0001, 32'h0},
    '{ROW_CFG, IDX_TOP, 32'hFFFF_FFFF, 32'h0},
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'h0000_0000, 32'h0000_0000},
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    // wide mode value keeps bit 0 only: stays encrypt
    '{ROW_CFG, teabc_pkg::CFG_DECRYPT, 32'hFFFF_FFFE, 32'h0},
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'h5555_AAAA, 32'hAAAA_5555},
    // wide mode value with bit 0 set: decrypt
    '{ROW_CFG, teabc_pkg::CFG_DECRYPT, 32'h0000_0003, 32'h0},
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'h0000_0000, 32'h0000_0000},
    '{ROW_BLK, teabc_pkg::CFG_KEY0, 32'hFFFF_FFFF, 32'h0000_0000}
  };

  // main stimulus
  initial begin
    bit cfg_open;
    teabc_pkg::tea_in_t blk;
    cfg_open = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (!cfg_open) quiesce();
        write_reg(directed_rows[i].idx, directed_rows[i].word_a);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_write <= 1'b0;
        cfg_open = 1'b0;
        blk.left_in  = directed_rows[i].word_a;
        blk.right_in = directed_rows[i].word_b;
        send_block(blk);
      end
    end

    run_phase($urandom(), $urandom(), $urandom(), $urandom(), 32'h0, PHASE_ITEMS, 0, 0);
    run_phase($urandom(), $urandom(), $urandom(), $urandom(), 32'h1, PHASE_ITEMS, 1, 0);
    run_phase('0, '0, '0, '0, 32'h1, PHASE_ITEMS, 0, 0);
    run_phase('1, '1, '1, '1, 32'h0, PHASE_ITEMS, 0, 1);
    run_phase(rand_word(), rand_word(), rand_word(), rand_word(), $urandom(),
              PHASE_ITEMS, 0, 0);
    run_phase(BOOT_KEY0, BOOT_KEY1, BOOT_KEY2, BOOT_KEY3, 32'h1, PHASE_ITEMS, 0, 0);
    run_phase($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              PHASE_ITEMS, 0, 0);
    run_phase($urandom(), $urandom(), $urandom(), $urandom(), 32'h0, PHASE_ITEMS, 0, 0);
    quiesce();

    if (fail_count == 0) begin
      $display("tea_block_cipher_unit regression: pass");
    end else begin
      $display("tea_block_cipher_unit regression: fail");
    end
    $finish;
  end

  // long receiver hold-off so the chain fills and stalls its input
  initial begin
    @(posedge clk iff hold_req);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // result checker and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (cipher_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result transaction: left %h right %h",
                     res_data.left_out, res_data.right_out);
        end else begin
          want_blk = cipher_q.pop_front();
          if (res_data.left_out !== want_blk.left_out ||
              res_data.right_out !== want_blk.right_out) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("result mismatch: expected left %h right %h, got left %h right %h",
                       want_blk.left_out, want_blk.right_out,
                       res_data.left_out, res_data.right_out);
          end
        end
      end
      res_stall <= hold_on || (!quiet && $urandom_range(99) < 6);
    end
  end

  // run limit
  initial begin
    #1ms;
    $display("tea_block_cipher_unit regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/teabc_pkg.sv
sv/teabc_cfg_regs.sv
sv/teabc_cell.sv
sv/tea_block_cipher_unit.sv
tb/tea_block_cipher_unit_tb.sv
